/* rtl/svpm_pkg.sv */
// ----------------------------------------------------------------------------
// svpm_pkg
// Shared constants, types and helpers of the phase voltage modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package svpm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int DUTY_FRAC_BITS = 15;
  localparam int NUM_W          = 16 + DUTY_FRAC_BITS;  // divider dividend width
  localparam int SINE_STAGES    = 6;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO   = 2'd2;

  localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] ANG_HALF    = {2'b10, {(ANGLE_BITS-2){1'b0}}};

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] SIN_C1  = 31'd1686629713;
  localparam logic [30:0] SIN_C3  = 31'd693598668;
  localparam logic [30:0] SIN_C5  = 31'd85569306;
  localparam logic [30:0] SIN_C7  = 31'd5026995;
  localparam logic [30:0] SIN_C9  = 31'd172272;

  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;  // floor(n/3) = n*RECIP3 >> 33

  localparam logic signed [63:0] SQRT3_S      = 64'sd1859775393;
  localparam logic signed [63:0] HALF_SQRT3_S = 64'sd929887697;

  localparam logic [15:0] DUTY_FULL = 16'(64'd1 << DUTY_FRAC_BITS);

  typedef struct packed {
    logic        neg;
    logic [30:0] x;
  } sarg_t;

  // word handed from front to back
  typedef struct packed {
    logic signed [16:0] volt;    // Uq in sine mode, |Uq| in SV mode
    logic [2:0]         sector;
    logic               neg_a;
    logic               neg_b;
    logic [31:0]        arg_a;   // sine arg, or dividend for /3 in SV mode
    logic [31:0]        arg_b;
  } item_t;

  function automatic logic [ANGLE_BITS-1:0] align_angle(input logic [15:0] v);
    logic [ANGLE_BITS+15:0] wide;
    wide = {v, {ANGLE_BITS{1'b0}}};
    return wide[ANGLE_BITS+15 -: ANGLE_BITS];
  endfunction

  // quadrant fold: quarter-turn fraction in Q30 plus sign
  function automatic sarg_t sine_arg(input logic [ANGLE_BITS-1:0] th);
    sarg_t       res;
    logic [30:0] frac;
    frac    = {1'b0, th[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
    res.neg = th[ANGLE_BITS-1];
    res.x   = th[ANGLE_BITS-2] ? (Q30_ONE - frac) : frac;
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/svpm_front.sv */
// ----------------------------------------------------------------------------
// svpm_front
// Takes a command word, folds angles and registers a classified word.
// ----------------------------------------------------------------------------
`default_nettype none

module svpm_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic signed [15:0]  vq_cmd,
  input  wire logic [15:0]         electrical_angle,
  input  wire logic                modulation_mode,
  input  wire logic [15:0]         zero_angle,
  output logic                     item_valid,
  output svpm_pkg::item_t          item
);
  import svpm_pkg::*;

  logic [ANGLE_BITS-1:0] ang, zer, th_sin, th_sv, ph;
  logic [ANGLE_BITS+2:0] t6;
  logic [ANGLE_BITS:0]   ph_rest;
  logic [15:0]           mag;
  sarg_t                 sa, sb;
  item_t                 item_next;

  always_comb begin
    ang    = align_angle(electrical_angle);
    zer    = align_angle(zero_angle);
    th_sin = ang + zer;
    sa     = sine_arg(th_sin);
    sb     = sine_arg(th_sin + ANG_QUARTER);

    // SV: negative command turns into magnitude plus half turn
    mag     = vq_cmd[15] ? (~vq_cmd + 16'd1) : vq_cmd;
    th_sv   = ang + (vq_cmd[15] ? ANG_HALF : '0) + zer + ANG_QUARTER;
    t6      = {th_sv, 2'b00} + {1'b0, th_sv, 1'b0};
    ph      = t6[ANGLE_BITS-1:0];
    ph_rest = {1'b1, {ANGLE_BITS{1'b0}}} - {1'b0, ph};

    if (modulation_mode) begin
      item_next.volt   = {1'b0, mag};
      item_next.sector = t6[ANGLE_BITS+2:ANGLE_BITS];
      item_next.neg_a  = 1'b0;
      item_next.neg_b  = 1'b0;
      item_next.arg_a  = {ph_rest, {(31-ANGLE_BITS){1'b0}}};
      item_next.arg_b  = {1'b0, ph, {(31-ANGLE_BITS){1'b0}}};
    end else begin
      item_next.volt   = 17'(vq_cmd);
      item_next.sector = 3'd0;
      item_next.neg_a  = sa.neg;
      item_next.neg_b  = sb.neg;
      item_next.arg_a  = {1'b0, sa.x};
      item_next.arg_b  = {1'b0, sb.x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= take;
    end
    item <= item_next;
  end

endmodule

`default_nettype wire

/* rtl/svpm_queue.sv */
// ----------------------------------------------------------------------------
// svpm_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module svpm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire svpm_pkg::item_t  push_item,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic                  full,
  output svpm_pkg::item_t       head
);
  import svpm_pkg::*;

  item_t      entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign do_pop    = pop && (count != 2'd0);
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/svpm_sine.sv */
// ----------------------------------------------------------------------------
// svpm_sine
// Pipelined quarter-wave sine: odd 9th-order polynomial, Horner in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module svpm_sine (
  input  wire logic        clk,
  input  wire logic [30:0] x,
  output logic [30:0]      r
);
  import svpm_pkg::*;

  localparam logic [30:0] COEF [4] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

  logic [30:0] x_s  [5];
  logic [30:0] x2_s [4];
  logic [30:0] p_s  [4];
  logic [61:0] sq, fin;
  logic [31:0] r_raw;

  assign sq    = 62'(x) * 62'(x);
  assign fin   = 62'(x_s[4]) * 62'(p_s[3]);
  assign r_raw = fin[61:30];

  always_ff @(posedge clk) begin
    x_s[0]  <= x;
    x2_s[0] <= sq[60:30];
    r       <= (r_raw > 32'(Q30_ONE)) ? Q30_ONE : r_raw[30:0];
  end

  for (genvar j = 0; j < 4; j++) begin : g_horner
    logic [30:0] p_in;
    logic [61:0] prod;
    if (j == 0) begin : g_first
      assign p_in = SIN_C9;
    end else begin : g_next
      assign p_in = p_s[j-1];
    end
    assign prod = 62'(x2_s[j]) * 62'(p_in);
    always_ff @(posedge clk) begin
      p_s[j]   <= COEF[j] - prod[60:30];
      x_s[j+1] <= x_s[j];
    end
    if (j < 3) begin : g_carry
      always_ff @(posedge clk) begin
        x2_s[j+1] <= x2_s[j];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/svpm_div.sv */
// ----------------------------------------------------------------------------
// svpm_div
// Pipelined restoring divider, one quotient bit per stage, with clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module svpm_div (
  input  wire logic             clk,
  input  wire logic [15:0]      supply,
  input  wire logic [svpm_pkg::NUM_W-1:0] num,
  input  wire logic             zero,
  input  wire logic             full,
  output logic [15:0]           duty
);
  import svpm_pkg::*;

  logic [NUM_W-1:0]          rem_r [DUTY_FRAC_BITS];
  logic [DUTY_FRAC_BITS-1:0] q_r   [DUTY_FRAC_BITS];
  logic                      z_r   [DUTY_FRAC_BITS];
  logic                      f_r   [DUTY_FRAC_BITS];

  for (genvar i = 0; i < DUTY_FRAC_BITS; i++) begin : g_step
    localparam int B = DUTY_FRAC_BITS - 1 - i;
    logic [NUM_W-1:0]          rem_in, dv;
    logic [DUTY_FRAC_BITS-1:0] q_in;
    logic                      z_in, f_in, ge;
    if (i == 0) begin : g_first
      assign rem_in = num;
      assign q_in   = '0;
      assign z_in   = zero;
      assign f_in   = full;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign z_in   = z_r[i-1];
      assign f_in   = f_r[i-1];
    end
    assign dv = NUM_W'(supply) << B;
    assign ge = (rem_in >= dv);
    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? (rem_in - dv) : rem_in;
      q_r[i]   <= {q_in[DUTY_FRAC_BITS-2:0], ge};
      z_r[i]   <= z_in;
      f_r[i]   <= f_in;
    end
  end

  always_comb begin
    if (z_r[DUTY_FRAC_BITS-1]) begin
      duty = 16'd0;
    end else if (f_r[DUTY_FRAC_BITS-1]) begin
      duty = DUTY_FULL;
    end else begin
      duty = 16'(q_r[DUTY_FRAC_BITS-1]);
    end
  end

endmodule

`default_nettype wire

/* rtl/svpm_back.sv */
// ----------------------------------------------------------------------------
// svpm_back
// Execution pipeline: sines, gains, voltage scaling, sector sums, duty divide.
// ----------------------------------------------------------------------------
`default_nettype none

module svpm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire svpm_pkg::item_t  item,
  input  wire logic             modulation_mode,
  input  wire logic [15:0]      supply_voltage,
  output logic                  done,
  output logic [15:0]           duty_a,
  output logic [15:0]           duty_b,
  output logic [15:0]           duty_c
);
  import svpm_pkg::*;

  typedef struct packed {
    logic signed [16:0] volt;
    logic [2:0]         sector;
    logic               neg_a;
    logic               neg_b;
  } side_t;

  localparam int DIV_AT = SINE_STAGES + 4;      // stage feeding the divider
  localparam int VLEN   = DIV_AT + DUTY_FRAC_BITS + 1;
  localparam int DW     = 52;

  logic  vp [VLEN];
  side_t sd [DIV_AT];

  // stage 0: divide by three for SV arguments
  logic [63:0] d3a, d3b;
  logic [30:0] x0a, x0b, ra, rb;
  assign d3a = 64'(item.arg_a) * 64'(RECIP3);
  assign d3b = 64'(item.arg_b) * 64'(RECIP3);

  always_ff @(posedge clk) begin
    x0a   <= modulation_mode ? d3a[63:33] : item.arg_a[30:0];
    x0b   <= modulation_mode ? d3b[63:33] : item.arg_b[30:0];
    sd[0] <= '{volt: item.volt, sector: item.sector, neg_a: item.neg_a, neg_b: item.neg_b};
    for (int i = 1; i < DIV_AT; i++) begin
      sd[i] <= sd[i-1];
    end
  end

  svpm_sine u_sine_a (.clk(clk), .x(x0a), .r(ra));
  svpm_sine u_sine_b (.clk(clk), .x(x0b), .r(rb));

  // stage 7: sign and constant scaling
  logic signed [31:0] sa_c, sb_c, s7;
  logic signed [63:0] pa7, pb7;
  assign sa_c = sd[SINE_STAGES].neg_a ? -signed'(32'(ra)) : signed'(32'(ra));
  assign sb_c = sd[SINE_STAGES].neg_b ? -signed'(32'(rb)) : signed'(32'(rb));

  always_ff @(posedge clk) begin
    s7  <= sa_c;
    pa7 <= 64'(sa_c) * SQRT3_S;
    pb7 <= 64'(sb_c) * (modulation_mode ? SQRT3_S : HALF_SQRT3_S);
  end

  // stage 8: phase gains (sine) or T1/T2 coefficients (SV)
  logic signed [63:0] half_s, sum_b, sum_c;
  logic signed [32:0] g8 [3];
  assign half_s = 64'(s7) <<< 29;
  assign sum_b  = (half_s + pb7) >>> 30;
  assign sum_c  = (half_s - pb7) >>> 30;

  always_ff @(posedge clk) begin
    if (modulation_mode) begin
      g8[0] <= 33'(pa7 >>> 30);
      g8[1] <= 33'(pb7 >>> 30);
      g8[2] <= '0;
    end else begin
      g8[0] <= -33'(s7);
      g8[1] <= sum_b[32:0];
      g8[2] <= sum_c[32:0];
    end
  end

  // stage 9: scale by voltage
  logic signed [49:0] m9 [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m9[i] <= 50'(g8[i]) * 50'(sd[SINE_STAGES+2].volt);
    end
  end

  // stage 10: doubled phase voltages, clamp flags, dividend
  logic signed [DW-1:0] base, full_lvl, w0, t1x2, t2x2, d [3];
  logic [NUM_W-1:0]     num_r [3];
  logic                 zero_r [3], full_r [3];
  logic [15:0]          dty [3];

  always_comb begin
    base     = signed'(DW'({supply_voltage, 30'd0}));
    full_lvl = signed'(DW'({supply_voltage, 31'd0}));
    t1x2     = DW'(m9[0]) <<< 1;
    t2x2     = DW'(m9[1]) <<< 1;
    w0       = base - DW'(m9[0]) - DW'(m9[1]);
    if (modulation_mode) begin
      case (sd[SINE_STAGES+3].sector)
        3'd0: begin
          d[0] = t1x2 + t2x2 + w0; d[1] = t2x2 + w0;        d[2] = w0;
        end
        3'd1: begin
          d[0] = t1x2 + w0;        d[1] = t1x2 + t2x2 + w0; d[2] = w0;
        end
        3'd2: begin
          d[0] = w0;               d[1] = t1x2 + t2x2 + w0; d[2] = t2x2 + w0;
        end
        3'd3: begin
          d[0] = w0;               d[1] = t1x2 + w0;        d[2] = t1x2 + t2x2 + w0;
        end
        3'd4: begin
          d[0] = t2x2 + w0;        d[1] = w0;               d[2] = t1x2 + t2x2 + w0;
        end
        default: begin
          d[0] = t1x2 + t2x2 + w0; d[1] = w0;               d[2] = t1x2 + w0;
        end
      endcase
    end else begin
      for (int i = 0; i < 3; i++) begin
        d[i] = (DW'(m9[i]) <<< 1) + base;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      zero_r[i] <= (d[i] <= 0);
      full_r[i] <= (d[i] >= full_lvl);
      num_r[i]  <= d[i][31-DUTY_FRAC_BITS +: NUM_W];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    svpm_div u_div (
      .clk(clk), .supply(supply_voltage), .num(num_r[i]),
      .zero(zero_r[i]), .full(full_r[i]), .duty(dty[i])
    );
  end

  // valid tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VLEN; i++) begin
        vp[i] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      vp[0] <= item_valid;
      for (int i = 1; i < VLEN; i++) begin
        vp[i] <= vp[i-1];
      end
      done <= vp[VLEN-1];
    end
    duty_a <= (supply_voltage == 16'd0) ? 16'd0 : dty[0];
    duty_b <= (supply_voltage == 16'd0) ? 16'd0 : dty[1];
    duty_c <= (supply_voltage == 16'd0) ? 16'd0 : dty[2];
  end

endmodule

`default_nettype wire

/* rtl/foc_phase_voltage_modulator.sv */
// ----------------------------------------------------------------------------
// foc_phase_voltage_modulator
// Sine / space-vector phase duty generator from Uq and electrical angle.
//
//   channel   signals                                   handshake
//   command   start, busy, vq_cmd, electrical_angle     start & !busy
//   result    done, duty_a, duty_b, duty_c              done, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid & cfg_ready
//
// One command word per cycle; done rises after the accepting edge, once the
// command has passed the front register and the queue, the divide-by-3
// stage, the 6-stage sine polynomial pipe, the gain, scaling and sum stages,
// the restoring divider that forms each duty, and the output register.
// Synchronous reset clears the control state and loads register defaults.
// The result side cannot stall and the back end pops the queue every cycle,
// so busy stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_phase_voltage_modulator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [15:0]                vq_cmd,
  input  wire logic [15:0]                       electrical_angle,
  output logic                                   done,
  output logic [15:0]                            duty_a,
  output logic [15:0]                            duty_b,
  output logic [15:0]                            duty_c,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [svpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                       cfg_data
);
  import svpm_pkg::*;

  logic        modulation_mode;
  logic [15:0] supply_voltage;
  logic [15:0] zero_angle;

  logic  take, front_valid, q_valid, q_full;
  item_t front_item, q_head;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign take      = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulation_mode <= 1'b0;
      supply_voltage  <= 16'd3072;
      zero_angle      <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:   modulation_mode <= cfg_data[0];
        REG_SUPPLY: supply_voltage  <= cfg_data;
        REG_ZERO:   zero_angle      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  svpm_front u_front (
    .clk(clk), .rst(rst), .take(take),
    .vq_cmd(vq_cmd), .electrical_angle(electrical_angle),
    .modulation_mode(modulation_mode), .zero_angle(zero_angle),
    .item_valid(front_valid), .item(front_item)
  );

  svpm_queue u_queue (
    .clk(clk), .rst(rst), .push(front_valid), .push_item(front_item),
    .pop(1'b1), .not_empty(q_valid), .full(q_full), .head(q_head)
  );

  svpm_back u_back (
    .clk(clk), .rst(rst), .item_valid(q_valid), .item(q_head),
    .modulation_mode(modulation_mode), .supply_voltage(supply_voltage),
    .done(done), .duty_a(duty_a), .duty_b(duty_b), .duty_c(duty_c)
  );

endmodule

`default_nettype wire
